// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the blitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
// The module that uses it must have clk and arst_n in scope.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cpb_pkg.sv =====
// Shared types and constants of the clipped pixel blitter.
package cpb_pkg;

	localparam int DIM_W   = 13;
	localparam int COL_W   = 12;
	localparam int ADDR_W  = 24;
	localparam int PIX_W   = 32;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	localparam int MAX_SCREEN_DIM_DEFAULT = 4096;

	// Largest image dimension in pixels or rows.
	localparam logic [DIM_W-1:0] IMG_MAX = 13'd4096;

	// Pixel format codes; the unused code behaves as plain copy.
	localparam logic [1:0] FMT_XRGB = 2'd0;
	localparam logic [1:0] FMT_RGBA = 2'd1;
	localparam logic [1:0] FMT_YUYV = 2'd2;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_FORMAT = 3'd0;
	localparam logic [2:0] REG_SCR_W  = 3'd1;
	localparam logic [2:0] REG_SCR_H  = 3'd2;
	localparam logic [2:0] REG_ORG_X  = 3'd3;
	localparam logic [2:0] REG_ORG_Y  = 3'd4;
	localparam logic [2:0] REG_IMG_W  = 3'd5;
	localparam logic [2:0] REG_IMG_H  = 3'd6;

	// Decoded and clamped configuration seen by the datapath.
	typedef struct packed {
		logic                    yuyv;
		logic                    rgba;
		logic [DIM_W-1:0]        scr_w;
		logic [DIM_W-1:0]        scr_h;
		logic signed [DIM_W-1:0] org_x;
		logic signed [DIM_W-1:0] org_y;
		logic [DIM_W-1:0]        img_w;
		logic [DIM_W-1:0]        img_h;
	} cfg_t;

endpackage

// ===== rtl/cpb_regs.sv =====
// Configuration registers of the blitter with an APB-style access port.
module cpb_regs #(
	parameter int MAX_SCREEN_DIM = cpb_pkg::MAX_SCREEN_DIM_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cpb_pkg::APB_AW-1:0] paddr,
	input  logic [cpb_pkg::APB_DW-1:0] pwdata,
	output logic [cpb_pkg::APB_DW-1:0] prdata,
	output cpb_pkg::cfg_t              cfg
);
	import cpb_pkg::*;

	// Screen dimensions cannot exceed what the 13-bit registers hold.
	localparam logic [DIM_W-1:0] SCR_CAP =
		(MAX_SCREEN_DIM > 8191) ? 13'd8191 : DIM_W'(MAX_SCREEN_DIM);

	logic [1:0]       fmt_q;
	logic [DIM_W-1:0] scr_w_q;
	logic [DIM_W-1:0] scr_h_q;
	logic [DIM_W-1:0] org_x_q;
	logic [DIM_W-1:0] org_y_q;
	logic [DIM_W-1:0] img_w_q;
	logic [DIM_W-1:0] img_h_q;
	logic             wr_en;
	logic [2:0]       reg_idx;

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] cap);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > cap) begin
			r = cap;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_AW-1:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_XRGB;
			scr_w_q <= 13'd1280;
			scr_h_q <= 13'd720;
			org_x_q <= '0;
			org_y_q <= '0;
			img_w_q <= 13'd1;
			img_h_q <= 13'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FORMAT: fmt_q   <= pwdata[1:0];
				REG_SCR_W:  scr_w_q <= pwdata[DIM_W-1:0];
				REG_SCR_H:  scr_h_q <= pwdata[DIM_W-1:0];
				REG_ORG_X:  org_x_q <= pwdata[DIM_W-1:0];
				REG_ORG_Y:  org_y_q <= pwdata[DIM_W-1:0];
				REG_IMG_W:  img_w_q <= pwdata[DIM_W-1:0];
				REG_IMG_H:  img_h_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (reg_idx)
			REG_FORMAT: prdata = {30'b0, fmt_q};
			REG_SCR_W:  prdata = {19'b0, scr_w_q};
			REG_SCR_H:  prdata = {19'b0, scr_h_q};
			REG_ORG_X:  prdata = {19'b0, org_x_q};
			REG_ORG_Y:  prdata = {19'b0, org_y_q};
			REG_IMG_W:  prdata = {19'b0, img_w_q};
			REG_IMG_H:  prdata = {19'b0, img_h_q};
			default:    prdata = '0;
		endcase
	end

	// Decoded format and clamped dimensions for the datapath.
	always_comb begin
		cfg.yuyv  = (fmt_q == FMT_YUYV);
		cfg.rgba  = (fmt_q == FMT_RGBA);
		cfg.scr_w = clamp_dim(scr_w_q, SCR_CAP);
		cfg.scr_h = clamp_dim(scr_h_q, SCR_CAP);
		cfg.org_x = $signed(org_x_q);
		cfg.org_y = $signed(org_y_q);
		cfg.img_w = clamp_dim(img_w_q, IMG_MAX);
		cfg.img_h = clamp_dim(img_h_q, IMG_MAX);
	end

endmodule

// ===== rtl/cpb_yuv2rgb.sv =====
// Crude YUV to RGB conversion of one pixel with clamping to 0..255.
module cpb_yuv2rgb (
	input  logic [7:0]                 luma,
	input  logic [7:0]                 cb,
	input  logic [7:0]                 cr,
	output logic [cpb_pkg::PIX_W-1:0]  rgb
);
	import cpb_pkg::*;

	localparam logic signed [9:0] CHROMA_BIAS = 10'sd128;
	// Bias of the green term: 128 divided by 8.
	localparam logic signed [9:0] GREEN_BIAS  = 10'sd16;

	logic signed [9:0] r_raw;
	logic signed [9:0] g_raw;
	logic signed [9:0] b_raw;
	logic [7:0]        r_sat;
	logic [7:0]        g_sat;
	logic [7:0]        b_sat;

	function automatic logic [7:0] sat8(logic signed [9:0] v);
		logic [7:0] r;
		if (v[9]) begin
			r = 8'h00;
		end else if (v[8]) begin
			r = 8'hFF;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// Unclamped color channels.
	assign r_raw = $signed({2'b0, luma}) + $signed({2'b0, cb}) - CHROMA_BIAS;
	assign g_raw = $signed({2'b0, luma}) - $signed({3'b0, luma[7:1]})
		- $signed({5'b0, cr[7:3]}) + GREEN_BIAS;
	assign b_raw = $signed({2'b0, luma}) + $signed({2'b0, cr}) - CHROMA_BIAS;

	// Clamp and pack as XRGB.
	assign r_sat = sat8(r_raw);
	assign g_sat = sat8(g_raw);
	assign b_sat = sat8(b_raw);
	assign rgb   = {8'h00, r_sat, g_sat, b_sat};

endmodule

// ===== rtl/clipped_pixel_blitter_yuyv_core.sv =====
// Top level of the clipped pixel blitter with packed YUYV expansion.
//
// Source words enter on the s_ stream in raster order of the image; each gives
// framebuffer writes on the m_ stream: address in m_tdata[23:0], pixel word in
// m_tdata[55:24], write enable in m_tuser[0], last result of the word in
// m_tuser[1], and m_tlast on the last result of the whole image.
// Pixels off screen come out with write enable low and zero address and data.
// Registers are to be set over the APB port while the block is idle; the block does not check this.
// An accepted word is held in the input stage, its results in the output
// register. XRGB and RGBA words give one result each; a YUYV word gives two, and
// its pixels leave one per cycle via the single output register unless stalled.
// The row product is formed in the input stage, the column add, clip compare
// and color conversion in the second; the output register holds the result.
// When the receiver stalls the output register holds and the input stage keeps
// one word waiting, after which s_tready drops.
// Reset clears the image row and column counters, empties both stages and
// loads the register defaults: XRGB, 1280 by 720 screen, origin 0, 1 by 1 image.
module clipped_pixel_blitter_yuyv_core #(
	parameter int MAX_SCREEN_DIM = cpb_pkg::MAX_SCREEN_DIM_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cpb_pkg::APB_AW-1:0] paddr,
	input  logic [cpb_pkg::APB_DW-1:0] pwdata,
	output logic [cpb_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // source_word
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [55:0]                m_tdata,   // write_address, pixel_value
	output logic [1:0]                 m_tuser,   // write_enable, last_of_item
	output logic                       m_tlast    // image_done
);
	import cpb_pkg::*;

	cfg_t cfg;

	// Image position counters.
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;

	// Input stage.
	logic                 s1_valid_q;
	logic                 phase_q;
	logic [PIX_W-1:0]     word_s1;
	logic                 yuyv_s1;
	logic                 rgba_s1;
	logic                 row_vis_s1;
	logic [ADDR_W-1:0]    row_base_s1;
	logic signed [14:0]   sx0_s1;
	logic                 second_in_s1;
	logic                 done_s1;

	// Output stage.
	logic                 out_valid_s2;
	logic                 we_s2;
	logic [ADDR_W-1:0]    addr_s2;
	logic [PIX_W-1:0]     pix_s2;
	logic                 last_s2;
	logic                 done_s2;

	logic                 in_accept;
	logic [DIM_W-1:0]     step;
	logic [DIM_W-1:0]     col_plus;
	logic [DIM_W-1:0]     row_plus;
	logic                 row_end;
	logic                 in_done;
	logic signed [14:0]   sy;
	logic signed [14:0]   sx0;
	logic                 row_vis;
	logic [25:0]          row_prod;
	logic                 second_in;

	logic                 out_free;
	logic                 emit;
	logic                 s1_final;
	logic signed [14:0]   sx;
	logic                 pix_vis;
	logic [ADDR_W-1:0]    pix_addr;
	logic [7:0]           luma;
	logic [PIX_W-1:0]     yuv_rgb;
	logic [PIX_W-1:0]     pix_value;

	cpb_regs #(
		.MAX_SCREEN_DIM(MAX_SCREEN_DIM)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Handshake between the stages.
	assign out_free  = !out_valid_s2 || m_tready;
	assign emit      = s1_valid_q && out_free;
	assign s1_final  = !yuyv_s1 || phase_q;
	assign s_tready  = !s1_valid_q || (emit && s1_final);
	assign in_accept = s_tvalid && s_tready;

	// Row and image end detection from the counters.
	assign step     = cfg.yuyv ? DIM_W'(2) : DIM_W'(1);
	assign col_plus = {1'b0, col_q} + step;
	assign row_plus = {1'b0, row_q} + DIM_W'(1);
	assign row_end  = (col_plus >= cfg.img_w);
	assign in_done  = row_end && (row_plus >= cfg.img_h);

	// Screen row, its visibility and its base address; first screen column.
	assign sy        = {{2{cfg.org_y[DIM_W-1]}}, cfg.org_y} + $signed({3'b0, row_q});
	assign row_vis   = !sy[14] && (sy[13:0] < {1'b0, cfg.scr_h});
	assign row_prod  = {13'b0, sy[DIM_W-1:0]} * {13'b0, cfg.scr_w};
	assign sx0       = {{2{cfg.org_x[DIM_W-1]}}, cfg.org_x} + $signed({3'b0, col_q});
	assign second_in = (({1'b0, col_q}) + DIM_W'(1)) < cfg.img_w;

	// Counters advance with each accepted word and wrap at the end of the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (in_done) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_plus[COL_W-1:0];
			end else begin
				col_q <= col_plus[COL_W-1:0];
			end
		end
	end

	// Input stage control: a YUYV word stays for two results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (emit && s1_final) begin
				s1_valid_q <= 1'b0;
			end
			if (emit) begin
				phase_q <= yuyv_s1 && !phase_q;
			end
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1      <= s_tdata;
			yuyv_s1      <= cfg.yuyv;
			rgba_s1      <= cfg.rgba;
			row_vis_s1   <= row_vis;
			row_base_s1  <= row_prod[ADDR_W-1:0];
			sx0_s1       <= sx0;
			second_in_s1 <= second_in;
			done_s1      <= in_done;
		end
	end

	// Column clip and address of the current pixel.
	assign sx       = sx0_s1 + $signed({14'b0, phase_q});
	assign pix_vis  = (!phase_q || second_in_s1) && row_vis_s1 && !sx[14]
		&& (sx[13:0] < {1'b0, cfg.scr_w});
	assign pix_addr = row_base_s1 + {10'b0, sx[13:0]};

	// Pixel word for the current format.
	assign luma = phase_q ? word_s1[15:8] : word_s1[31:24];

	cpb_yuv2rgb u_yuv2rgb (
		.luma (luma),
		.cb   (word_s1[7:0]),
		.cr   (word_s1[23:16]),
		.rgb  (yuv_rgb)
	);

	always_comb begin
		priority if (yuyv_s1) begin
			pix_value = yuv_rgb;
		end else if (rgba_s1) begin
			pix_value = {8'h00, word_s1[31:8]};
		end else begin
			pix_value = word_s1;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (emit) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Output register payload; invisible pixels carry zero address and data.
	always_ff @(posedge clk) begin
		if (emit) begin
			we_s2   <= pix_vis;
			addr_s2 <= pix_vis ? pix_addr : '0;
			pix_s2  <= pix_vis ? pix_value : '0;
			last_s2 <= s1_final;
			done_s2 <= s1_final && done_s1;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {pix_s2, addr_s2};
	assign m_tuser  = {last_s2, we_s2};
	assign m_tlast  = done_s2;

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_done_only_on_last, out_valid_s2 && done_s2, last_s2,
		"Image end flagged on a result that is not the last of its item.")
	`ASSERT_IMPL(a_blank_when_off, out_valid_s2 && !we_s2,
		(addr_s2 == '0) && (pix_s2 == '0),
		"Invisible pixel carries a nonzero address or value.")
	`ASSERT_IMPL(a_second_phase_yuyv, phase_q, s1_valid_q && yuyv_s1,
		"Second pixel phase without a YUYV word in the input stage.")
	`ASSERT_NEXT(a_wrap_after_done, in_accept && in_done,
		(col_q == '0) && (row_q == '0),
		"Counters did not wrap after the last word of the image.")

endmodule

// ===== dv/tb_clipped_pixel_blitter_yuyv_core.sv =====
// Self-checking testbench of the clipped pixel blitter with YUYV expansion.
module tb_clipped_pixel_blitter_yuyv_core;
	import cpb_pkg::*;

	// The spare format code, expected to behave as a plain copy.
	localparam logic [1:0] FMT_UNUSED = 2'd3;
	localparam int SCREEN_MAX  = MAX_SCREEN_DIM_DEFAULT;
	localparam int WORD_TARGET = 1650;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 4;
	localparam int CYCLE_LIMIT = 1_000_000;

	// One framebuffer write as the block should present it.
	typedef struct packed {
		bit        enable;
		bit [23:0] address;
		bit [31:0] pixel;
		bit        last_of_word;
		bit        image_end;
	} fb_write_t;

	// Tracks the register file and the image position, and holds the writes still owed.
	class blit_scoreboard;
		bit [1:0]         fmt;
		bit [12:0]        scr_w;
		bit [12:0]        scr_h;
		bit signed [12:0] org_x;
		bit signed [12:0] org_y;
		bit [12:0]        img_w;
		bit [12:0]        img_h;
		bit [11:0]        col;
		bit [11:0]        row;
		fb_write_t        awaited[$];
		int               errors;
		int               checked;
		int               on_screen;
		int               images;

		function new();
			fmt = FMT_XRGB;
			scr_w = 13'd1280;
			scr_h = 13'd720;
			org_x = 13'sd0;
			org_y = 13'sd0;
			img_w = 13'd1;
			img_h = 13'd1;
			col = '0;
			row = '0;
		endfunction

		function void write_reg(bit [2:0] idx, bit [12:0] v);
			case (idx)
				REG_FORMAT: fmt = v[1:0];
				REG_SCR_W:  scr_w = v;
				REG_SCR_H:  scr_h = v;
				REG_ORG_X:  org_x = v;
				REG_ORG_Y:  org_y = v;
				REG_IMG_W:  img_w = v;
				REG_IMG_H:  img_h = v;
				default:    ;
			endcase
		endfunction

		function int clamp_dim(bit [12:0] v, int hi);
			if (v == 0)
				return 1;
			if (int'(v) > hi)
				return hi;
			return int'(v);
		endfunction

		function bit [7:0] sat8(int v);
			if (v < 0)
				return 8'd0;
			if (v > 255)
				return 8'd255;
			return 8'(v);
		endfunction

		// Crude YUV to RGB: chroma minus 128, green takes an eighth of V.
		function bit [31:0] yuv_pixel(bit [7:0] y, bit [7:0] u, bit [7:0] v);
			int r;
			int g;
			int b;
			r = int'(y) + int'(u) - 128;
			g = int'(y) - int'(y >> 1) - (int'(v >> 3) - 16);
			b = int'(y) + int'(v) - 128;
			return {8'h00, sat8(r), sat8(g), sat8(b)};
		endfunction

		// Clips one pixel at image column c of the current row against the screen.
		function fb_write_t place(bit in_image, int c, bit [31:0] value, bit last_w,
				bit end_img);
			fb_write_t wr;
			int sw;
			int sh;
			int sx;
			int sy;
			sw = clamp_dim(scr_w, SCREEN_MAX);
			sh = clamp_dim(scr_h, SCREEN_MAX);
			sx = int'(org_x) + c;
			sy = int'(org_y) + int'(row);
			wr.enable = in_image && sx >= 0 && sy >= 0 && sx < sw && sy < sh;
			wr.address = wr.enable ? 24'(sy * sw + sx) : 24'd0;
			wr.pixel = wr.enable ? value : 32'd0;
			wr.last_of_word = last_w;
			wr.image_end = end_img;
			return wr;
		endfunction

		// Works out the writes of one accepted source word and steps the position.
		function void note_word(bit [31:0] w);
			int  iw;
			int  ih;
			int  stride;
			bit  yuyv;
			bit  row_end;
			bit  img_end;
			iw = clamp_dim(img_w, int'(IMG_MAX));
			ih = clamp_dim(img_h, int'(IMG_MAX));
			yuyv = (fmt == FMT_YUYV);
			stride = yuyv ? 2 : 1;
			row_end = int'(col) + stride >= iw;
			img_end = row_end && int'(row) + 1 >= ih;
			if (yuyv) begin
				awaited.push_back(place(1'b1, int'(col),
					yuv_pixel(w[31:24], w[7:0], w[23:16]), 1'b0, 1'b0));
				awaited.push_back(place(int'(col) + 1 < iw, int'(col) + 1,
					yuv_pixel(w[15:8], w[7:0], w[23:16]), 1'b1, img_end));
			end else begin
				awaited.push_back(place(1'b1, int'(col),
					(fmt == FMT_RGBA) ? (w >> 8) : w, 1'b1, img_end));
			end
			if (img_end) begin
				col = '0;
				row = '0;
			end else if (row_end) begin
				col = '0;
				row = row + 12'd1;
			end else begin
				col = col + 12'(stride);
			end
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			return got === want;
		endfunction

		// Compares one write leaving the block with the oldest one owed.
		function void check_write(logic [55:0] tdata, logic [1:0] tuser, logic tl);
			fb_write_t want;
			bit        ok;
			if (awaited.size() == 0) begin
				$display("%0t: write with none expected: expected nothing got tdata=%h tuser=%b tlast=%b",
					$time, tdata, tuser, tl);
				errors++;
				return;
			end
			want = awaited.pop_front();
			ok = field_ok("write_enable", 32'(want.enable), 32'(tuser[0]))
				& field_ok("write_address", 32'(want.address), 32'(tdata[23:0]))
				& field_ok("pixel_value", want.pixel, tdata[55:24])
				& field_ok("last_of_item", 32'(want.last_of_word), 32'(tuser[1]))
				& field_ok("image_done", 32'(want.image_end), 32'(tl));
			if (!ok)
				errors++;
			checked++;
			if (want.enable)
				on_screen++;
			if (want.image_end)
				images++;
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;   // source_word
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [55:0]       m_tdata;   // write_address, pixel_value
	logic [1:0]        m_tuser;   // write_enable, last_of_item
	logic              m_tlast;   // image_done

	blit_scoreboard sb;
	int             words_sent;
	int             settings_used;
	bit             send_calm;
	bit             take_calm;
	int             holds_asked;
	int             holds_done;
	int             ready_wait;
	int             cycles;

	clipped_pixel_blitter_yuyv_core #(.MAX_SCREEN_DIM(SCREEN_MAX)) dut (.*);

	// Clock with a period of 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	// Dimension register value: mostly small, sometimes extreme or out of range.
	function automatic int pick_dim(int usual);
		case ($urandom_range(0, 19))
			0:       return 1;
			1:       return 4096;
			2:       return $urandom_range(0, 8191);
			3:       return $urandom_range(1, 4096);
			default: return $urandom_range(1, usual);
		endcase
	endfunction

	// Receiver: random stalls, plus long hold-offs on request.
	always @(posedge clk) begin
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (ready_wait != 0) begin
			ready_wait = ready_wait - 1;
			m_tready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			ready_wait = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else begin
			stall = pick_gap(take_calm);
			ready_wait = (stall > 0) ? stall - 1 : 0;
			m_tready <= (stall == 0);
		end
	end

	// Every write leaving the block is checked as it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_write(m_tdata, m_tuser, m_tlast);
	end

	// Watchdog on the whole run.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d writes still owed", cycles, sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

	// Offers one source word after a random gap and waits until it is taken.
	task automatic send_word(bit [31:0] w);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		sb.note_word(w);
		words_sent++;
	endtask

	// Stops sending and waits until every owed write has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write: setup cycle, then access cycle until pready.
	task automatic apb_write(bit [2:0] idx, int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val) & 32'h1FFF;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, 13'(val));
	endtask

	// Rewrites every register once the block has gone idle.
	task automatic set_config(int fmt, int sw, int sh, int ox, int oy, int iw, int ih);
		drain();
		apb_write(REG_FORMAT, fmt);
		apb_write(REG_SCR_W, sw);
		apb_write(REG_SCR_H, sh);
		apb_write(REG_ORG_X, ox);
		apb_write(REG_ORG_Y, oy);
		apb_write(REG_IMG_W, iw);
		apb_write(REG_IMG_H, ih);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	// Random setting; words is mostly whole images, sometimes a broken run.
	task automatic random_setting(output int words);
		int fmt;
		int sw;
		int sh;
		int iw;
		int ih;
		int ox;
		int oy;
		int lead;
		int stride;
		int per_image;
		case ($urandom_range(0, 9))
			0, 1, 2: fmt = FMT_XRGB;
			3, 4, 5: fmt = FMT_RGBA;
			9:       fmt = FMT_UNUSED;
			default: fmt = FMT_YUYV;
		endcase
		sw = pick_dim(48);
		sh = pick_dim(32);
		iw = pick_dim(12);
		ih = pick_dim(6);
		if (fmt == FMT_YUYV && iw < 4096 && iw[0] && $urandom_range(0, 3) != 0)
			iw++;
		// Origins mostly put the image partly across a screen edge.
		case ($urandom_range(0, 9))
			0:       ox = -4096;
			1:       ox = 4095;
			2:       ox = int'($urandom_range(0, 8191)) - 4096;
			default: begin
				lead = sb.clamp_dim(13'(iw), 32);
				ox = int'($urandom_range(0, sb.clamp_dim(13'(sw), SCREEN_MAX) + lead)) - lead;
			end
		endcase
		case ($urandom_range(0, 9))
			0:       oy = -4096;
			1:       oy = 4095;
			2:       oy = int'($urandom_range(0, 8191)) - 4096;
			default: begin
				lead = sb.clamp_dim(13'(ih), 8);
				oy = int'($urandom_range(0, sb.clamp_dim(13'(sh), SCREEN_MAX) + lead)) - lead;
			end
		endcase
		if (ox > 4095)
			ox = 4095;
		if (oy > 4095)
			oy = 4095;
		stride = (fmt == FMT_YUYV) ? 2 : 1;
		per_image = (sb.clamp_dim(13'(iw), 4096) + stride - 1) / stride
			* sb.clamp_dim(13'(ih), 4096);
		if ($urandom_range(0, 4) == 0)
			words = $urandom_range(1, 40);
		else if (per_image <= 120)
			words = per_image * $urandom_range(1, 3);
		else
			words = $urandom_range(1, 60);
		set_config(fmt, sw, sh, ox, oy, iw, ih);
	endtask

	initial begin
		int burst;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: a one-pixel image at the screen corner.
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_word(32'hA5A5_5A5A);

		// RGBA shift on a small screen, image hanging off the top left corner.
		set_config(FMT_RGBA, 4, 3, -1, -1, 3, 2);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_word(32'h8000_0001);
		send_word(32'h7FFF_FFFE);
		send_word(32'h1234_5678);
		send_word(32'h89AB_CDEF);

		// YUYV with odd width, so each row ends with a pixel past the right edge.
		set_config(FMT_YUYV, 3, 2, 1, 0, 3, 2);
		send_word(32'hFF00_00FF);
		send_word(32'h00FF_FF00);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);

		// Mid-scale chroma and color clamping at both ends.
		set_config(FMT_YUYV, 8, 8, 0, 0, 4, 1);
		send_word(32'h8080_8080);
		send_word(32'h10F0_F010);

		// Unused format code and dimension registers outside their range.
		set_config(FMT_UNUSED, 0, 8191, 0, 4095, 0, 8191);
		send_word(32'hDEAD_BEEF);
		send_word(32'h0F0F_F0F0);
		send_word(32'hFFFF_0000);

		// Largest screen, image starting on the last framebuffer pixel.
		set_config(FMT_XRGB, 4096, 4096, 4095, 4095, 4096, 4096);
		send_word(32'hC0FF_EE00);
		send_word(32'h0000_FFFF);

		// Image shrunk while the column counter already sits past the new width.
		set_config(FMT_XRGB, 16, 16, 0, 0, 2, 2);
		send_word(32'h5555_AAAA);
		send_word(32'hAAAA_5555);
		send_word(32'h0123_4567);

		// Random settings and content; now and then a long receiver hold-off.
		while (words_sent < WORD_TARGET) begin
			random_setting(burst);
			send_calm = ($urandom_range(0, 3) == 0);
			take_calm = ($urandom_range(0, 3) == 0);
			if (settings_used % 20 == 5) begin
				holds_asked++;
				if (burst < 24)
					burst = 24;
			end
			repeat (burst) send_word($urandom());
		end
		drain();

		$display("Run covered %0d source words under %0d register settings, with long output holds",
			words_sent, settings_used);
		$display("and idle pauses; %0d writes checked, %0d on screen, %0d image ends.",
			sb.checked, sb.on_screen, sb.images);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
